### hw/rtl/cidr_first_match_acl_core_assert.svh
// assertion macros used by the acl core
`ifndef CIDR_FIRST_MATCH_ACL_CORE_ASSERT_SVH
`define CIDR_FIRST_MATCH_ACL_CORE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define ACL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cfma_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// cfma_pkg
// Types and constants of the first-match cidr access rule table.
// ------------------------------------------------------------------------
package cfma_pkg;

    // table size and derived widths
    localparam int MAX_RULES = 16;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    // function codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;

    // verdict codes
    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_ALLOW  = 2'd1;
    localparam logic [1:0] VERDICT_FORBID = 2'd2;

    // request payload
    typedef struct packed {
        logic        func;
        logic [31:0] address;
        logic [31:0] net_mask;
        logic        deny_flag;
    } t_acl_req;

    // response payload
    typedef struct packed {
        logic [1:0] verdict;
        logic       table_full;
    } t_acl_rsp;

    // token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        func;
        logic [31:0] address;
        logic [31:0] net_mask;
        logic        deny_flag;
        logic        decided;
        logic [1:0]  verdict;
    } t_cell_tok;

endpackage

### hw/rtl/cfma_cell.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// cfma_cell
// One rule slot: stores a rule on append, matches it on check, and passes
// the request token on to the next slot.
// ------------------------------------------------------------------------
module cfma_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic [cfma_pkg::IDX_W-1:0] i_index,
    input  logic [cfma_pkg::CNT_W-1:0] i_count,
    input  cfma_pkg::t_cell_tok     i_tok,
    output cfma_pkg::t_cell_tok     o_tok
);
    import cfma_pkg::*;

    logic [31:0] r_net;
    logic [31:0] r_mask;
    logic        r_deny;
    t_cell_tok   r_tok;
    t_cell_tok   n_tok;
    logic        slot_used;
    logic        slot_free;
    logic        hit;

    // slot position against the fill count
    assign slot_used = CNT_W'(i_index) < i_count;
    assign slot_free = CNT_W'(i_index) == i_count;
    assign hit       = (i_tok.address & r_mask) == r_net;

    // first matching rule decides
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && (i_tok.func == FUNC_CHECK) && slot_used
                && !i_tok.decided && hit) begin
            n_tok.decided = 1'b1;
            n_tok.verdict = r_deny ? VERDICT_FORBID : VERDICT_ALLOW;
        end
    end

    // rule storage, written once at the first free slot
    always_ff @(posedge i_clk) begin
        if (i_advance && i_tok.valid && (i_tok.func == FUNC_APPEND) && slot_free) begin
            r_net  <= i_tok.address & i_tok.net_mask;
            r_mask <= i_tok.net_mask;
            r_deny <= i_tok.deny_flag;
        end
    end

    // token register toward the next slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### hw/rtl/cidr_first_match_acl_core.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// cidr_first_match_acl_core
// Ordered ipv4 cidr access rule table with first-match lookup.
// ------------------------------------------------------------------------
// usage
//   requests come in on i_in_valid / o_in_stall with payload i_in_req;
//   func append stores a rule in the next free slot, func check looks
//   an address up against the stored rules in insertion order.
//   one response per request leaves on o_out_valid / i_out_stall with
//   payload o_out_rsp (verdict, table_full).
//   a request walks a chain of MAX_RULES rule slots, one slot per cycle,
//   then lands in the output register. only one request is in the chain
//   at a time, so a new request is taken only once the previous one has
//   left the chain. the input opens again in the cycle the response
//   lands, even while that response is still waiting.
//   when the receiver stalls with a response held, a following request
//   parks in the last slot until the output register frees up.
//   reset empties the table (fill count zero) and drops any request in
//   flight; rule contents are not cleared.
// ------------------------------------------------------------------------
module cidr_first_match_acl_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cfma_pkg::t_acl_req i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cfma_pkg::t_acl_rsp o_out_rsp
);
    import cfma_pkg::*;

    t_cell_tok            chain_tok [MAX_RULES+1];
    t_cell_tok            head_tok;
    logic [MAX_RULES-1:0] cell_valid;
    logic                 busy;
    logic                 advance;
    logic                 in_take;
    logic                 tail_exit;
    t_cell_tok            tail_tok;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    t_acl_rsp             r_out_rsp;

    // chain occupancy and flow control
    assign busy       = |cell_valid;
    assign o_in_stall = busy;
    assign in_take    = i_in_valid && !busy;
    assign tail_tok   = chain_tok[MAX_RULES];
    assign advance    = !(tail_tok.valid && r_out_valid && i_out_stall);
    assign tail_exit  = advance && tail_tok.valid;

    // request enters the first slot
    always_comb begin
        head_tok           = '0;
        head_tok.valid     = in_take;
        head_tok.func      = i_in_req.func;
        head_tok.address   = i_in_req.address;
        head_tok.net_mask  = i_in_req.net_mask;
        head_tok.deny_flag = i_in_req.deny_flag;
        head_tok.decided   = 1'b0;
        head_tok.verdict   = VERDICT_NONE;
    end

    assign chain_tok[0] = head_tok;

    // row of rule slots
    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        cfma_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_index   (IDX_W'(g)),
            .i_count   (r_count),
            .i_tok     (chain_tok[g]),
            .o_tok     (chain_tok[g+1])
        );
        assign cell_valid[g] = chain_tok[g+1].valid;
    end

    // fill count, bumped when an accepted append leaves the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (tail_exit && (tail_tok.func == FUNC_APPEND)
                && (r_count < CNT_W'(MAX_RULES))) begin
            r_count <= r_count + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tail_exit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_exit) begin
            r_out_rsp.verdict    <= tail_tok.verdict;
            r_out_rsp.table_full <= (tail_tok.func == FUNC_APPEND)
                                    && (r_count == CNT_W'(MAX_RULES));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // checks
    `include "cidr_first_match_acl_core_assert.svh"

    `ACL_ASSERT_ALWAYS(a_single_token, $onehot0(cell_valid), "more than one request in the chain")
    `ACL_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(MAX_RULES), "fill count beyond table size")
    `ACL_ASSERT_NEXT(a_enter_chain, in_take, chain_tok[1].valid, "taken request missing in slot 0")
    `ACL_ASSERT_NEXT(a_append_verdict, tail_exit && (tail_tok.func == FUNC_APPEND), o_out_valid && (o_out_rsp.verdict == VERDICT_NONE), "append gave a verdict")

endmodule

### test/cidr_first_match_acl_check.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// cidr_first_match_acl_check
// Watches both channels of the acl core, keeps its own copy of the rule
// table, works out the response of every accepted request and compares
// each accepted response with the oldest one still owed.
// ------------------------------------------------------------------------
module cidr_first_match_acl_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  cfma_pkg::t_acl_req i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cfma_pkg::t_acl_rsp i_out_rsp,
    output int                 o_fail_count,
    output int                 o_pending
);
    import cfma_pkg::*;

    // shadow rule table, filled in append order
    logic [31:0] shadow_net  [MAX_RULES];
    logic [31:0] shadow_mask [MAX_RULES];
    logic        shadow_deny [MAX_RULES];
    int          shadow_used = 0;

    t_acl_rsp    owed_rsp_q[$];
    int          mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // first rule in insertion order whose masked address equals its network
    function automatic logic [1:0] first_match_verdict(input logic [31:0] addr);
        for (int k = 0; k < shadow_used; k++) begin
            if ((addr & shadow_mask[k]) == shadow_net[k]) begin
                return shadow_deny[k] ? VERDICT_FORBID : VERDICT_ALLOW;
            end
        end
        return VERDICT_NONE;
    endfunction

    // apply one request to the shadow table and return its response
    function automatic t_acl_rsp acl_response(input t_acl_req req);
        t_acl_rsp rsp;
        rsp.verdict    = VERDICT_NONE;
        rsp.table_full = 1'b0;
        if (req.func == FUNC_APPEND) begin
            if (shadow_used >= MAX_RULES) begin
                rsp.table_full = 1'b1;
            end else begin
                shadow_net[shadow_used]  = req.address & req.net_mask;
                shadow_mask[shadow_used] = req.net_mask;
                shadow_deny[shadow_used] = req.deny_flag;
                shadow_used++;
            end
        end else begin
            rsp.verdict = first_match_verdict(req.address);
        end
        return rsp;
    endfunction

    // count a mismatch, print only the first few
    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns mismatch: %s", $realtime, msg);
        end
    endtask

    // response side first, then the request taken at the same edge
    always @(posedge i_clk) begin : watch
        t_acl_rsp want;
        if (!i_rst_n) begin
            shadow_used = 0;
            owed_rsp_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_rsp_q.size() == 0) begin
                    flag_mismatch($sformatf("response with none owed: verdict %0d table_full %0d",
                                            i_out_rsp.verdict, i_out_rsp.table_full));
                end else begin
                    want = owed_rsp_q.pop_front();
                    if (i_out_rsp.verdict !== want.verdict) begin
                        flag_mismatch($sformatf("verdict expected %0d actual %0d",
                                                want.verdict, i_out_rsp.verdict));
                    end
                    if (i_out_rsp.table_full !== want.table_full) begin
                        flag_mismatch($sformatf("table_full expected %0d actual %0d",
                                                want.table_full, i_out_rsp.table_full));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_rsp_q.push_back(acl_response(i_in_req));
            end
        end
        o_pending    <= owed_rsp_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### test/cidr_first_match_acl_core_test.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// cidr_first_match_acl_core_test
// Drives the acl core with a directed set of appends and checks, then
// random traffic that fills the table gradually, ends it with a catch-all
// rule and keeps appending to the full table. Both sides idle at random;
// the checker beside the core does the prediction and comparison.
// ------------------------------------------------------------------------
module cidr_first_match_acl_core_test;
    import cfma_pkg::*;

    localparam int RANDOM_ITEMS     = 1340;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = MAX_RULES + 8;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_acl_req in_req;
    logic     out_valid;
    logic     out_stall;
    t_acl_rsp out_rsp;
    int       fail_count;
    int       pending;

    // rules as sent, used to aim check addresses at them
    logic [31:0] sent_net  [MAX_RULES];
    logic [31:0] sent_mask [MAX_RULES];
    int          rules_sent    = 0;
    int          items_offered = 0;

    cidr_first_match_acl_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    cidr_first_match_acl_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_rsp    (out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // give up long after the slowest legal run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one request, return at the edge that takes it
    task automatic offer(input logic fn, input logic [31:0] addr,
                         input logic [31:0] mask, input logic deny);
        t_acl_req req;
        int       gap;
        req.func      = fn;
        req.address   = addr;
        req.net_mask  = mask;
        req.deny_flag = deny;
        if (fn == FUNC_APPEND && rules_sent < MAX_RULES) begin
            sent_net[rules_sent]  = addr & mask;
            sent_mask[rules_sent] = mask;
            rules_sent++;
        end
        // every fourth stretch of 100 requests goes back to back
        gap = (((items_offered / 100) % 4) == 1) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        items_offered++;
    endtask

    // response side: random hold-off per response, one long hold
    initial begin : receiver
        int hold;
        int taken;
        taken = 0;
        out_stall <= 1'b0;
        forever begin
            hold = (((taken / 100) % 4) == 2) ? 0 : $urandom_range(0, 10);
            if (taken == 300) begin
                hold = LONG_HOLD_CYCLES;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // request side: reset, directed requests, random traffic, drain
    initial begin : stimulus
        logic [31:0] addr;
        logic [31:0] mask;
        int          pick;
        int          k;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_req   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // checks on the empty table
        offer(FUNC_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b0);
        offer(FUNC_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // host bits in the appended network are dropped
        offer(FUNC_APPEND, 32'h0A01_374D, 32'hFFFF_0000, 1'b0);
        offer(FUNC_CHECK,  32'h0A01_C803, 32'h1234_5678, 1'b1);
        offer(FUNC_CHECK,  32'h0A02_0001, 32'h0000_0000, 1'b0);
        // narrower deny rule shadowed by the earlier allow
        offer(FUNC_APPEND, 32'h0A01_8000, 32'hFFFF_8000, 1'b1);
        offer(FUNC_CHECK,  32'h0A01_8201, 32'h0000_0000, 1'b0);
        offer(FUNC_APPEND, 32'hC0A8_07FF, 32'hFFFF_FF00, 1'b1);
        offer(FUNC_CHECK,  32'hC0A8_0709, 32'h0000_0000, 1'b0);
        offer(FUNC_CHECK,  32'hC0A8_06FF, 32'hFFFF_FFFF, 1'b0);
        // single-host rules at both address extremes
        offer(FUNC_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        offer(FUNC_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        offer(FUNC_CHECK,  32'hFFFF_FFFE, 32'h0000_0000, 1'b1);
        offer(FUNC_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        offer(FUNC_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        offer(FUNC_CHECK,  32'h0000_0001, 32'h0000_0000, 1'b0);

        // random traffic: the table fills slowly, the last rule is a catch-all
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // pause once until every owed response is back
            if (n == 700) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            if (rules_sent < MAX_RULES) begin
                pick = ($urandom_range(0, 24) == 0) ? 1 : 0;
            end else begin
                pick = ($urandom_range(0, 9) == 0) ? 1 : 0;
            end
            if (pick == 1) begin
                if (rules_sent == MAX_RULES - 1) begin
                    mask = 32'h0000_0000;
                end else if ($urandom_range(0, 7) == 0) begin
                    mask = $urandom;
                end else begin
                    mask = 32'hFFFF_FFFF << (32 - $urandom_range(8, 32));
                end
                offer(FUNC_APPEND, $urandom, mask, 1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 9);
                if (rules_sent > 0 && pick < 7) begin
                    k    = $urandom_range(0, rules_sent - 1);
                    addr = sent_net[k] | ($urandom & ~sent_mask[k]);
                    // sometimes knock one bit to land just beside the rule
                    if (pick == 6) begin
                        addr = addr ^ (32'd1 << $urandom_range(0, 31));
                    end
                end else begin
                    addr = $urandom;
                end
                offer(FUNC_CHECK, addr, $urandom, 1'($urandom_range(0, 1)));
            end
        end

        // drain and report
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
